// ----- rtl/core/lpfp_pkg.sv -----
// ----------------------------------------------------------------------------
// lpfp_pkg
// Shared types and codes of the length-prefixed frame parser.
// ----------------------------------------------------------------------------
package lpfp_pkg;

    // Header layout
    localparam int unsigned HDR_BYTES   = 8;
    localparam int unsigned HDR_CNT_W   = 4;   // holds 0..HDR_BYTES
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 64;

    // Input operation codes
    localparam logic OP_PUSH     = 1'b0;
    localparam logic OP_SOFT_RST = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_MORE  = 3'd0;
    localparam logic [2:0] ST_FRAME = 3'd1;
    localparam logic [2:0] ST_TYPE  = 3'd2;
    localparam logic [2:0] ST_LEN   = 3'd3;
    localparam logic [2:0] ST_CAP   = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_MASK_0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_MASK_1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_MASK_2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_MASK_3 = 3'd5;

    typedef struct packed {
        logic [31:0]       max_payload;
        logic [31:0]       capacity;
        logic [3:0][63:0]  type_mask;
    } t_cfg;

    typedef struct packed {
        logic [HDR_CNT_W-1:0] hdr_cnt;
        logic [7:0]           frame_type;
        logic [15:0]          request_id;
        logic [31:0]          length;
        logic [31:0]          pay_cnt;
        logic                 poisoned;
    } t_state;

    typedef struct packed {
        logic [2:0]  status;
        logic        accepted;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [31:0] payload_offset;
        logic [7:0]  frame_type;
        logic [15:0] request_id;
        logic [31:0] payload_length;
    } t_result;

endpackage

// ----- rtl/core/lpfp_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// lpfp_cfg_regs
// Configuration registers: limits and the 256-entry type mask.
// ----------------------------------------------------------------------------
module lpfp_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lpfp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lpfp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output lpfp_pkg::t_cfg                      o_cfg
);
    import lpfp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_PAYLOAD: r_cfg.max_payload  <= i_cfg_data[31:0];
                CFG_CAPACITY:    r_cfg.capacity     <= i_cfg_data[31:0];
                CFG_TYPE_MASK_0: r_cfg.type_mask[0] <= i_cfg_data;
                CFG_TYPE_MASK_1: r_cfg.type_mask[1] <= i_cfg_data;
                CFG_TYPE_MASK_2: r_cfg.type_mask[2] <= i_cfg_data;
                CFG_TYPE_MASK_3: r_cfg.type_mask[3] <= i_cfg_data;
                default: begin
                    // unmapped index: ignored
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/lpfp_step.sv -----
// ----------------------------------------------------------------------------
// lpfp_step
// Next-state and result logic for one stream byte or soft reset.
// ----------------------------------------------------------------------------
module lpfp_step (
    input  logic              i_op,
    input  logic [7:0]        i_data_byte,
    input  lpfp_pkg::t_cfg    i_cfg,
    input  lpfp_pkg::t_state  i_state,
    output lpfp_pkg::t_state  o_state,
    output lpfp_pkg::t_result o_result
);
    import lpfp_pkg::*;

    t_state      n_state;
    logic [2:0]  n_status;
    logic        n_acc;
    logic        n_pv;
    logic [31:0] len_full;
    logic [31:0] pay_next;
    logic        type_known;
    logic        in_header;

    assign in_header  = (i_state.hdr_cnt < HDR_CNT_W'(HDR_BYTES));
    // Eighth header byte completes the length's top byte
    assign len_full   = {i_data_byte, i_state.length[23:0]};
    assign pay_next   = i_state.pay_cnt + 32'd1;
    assign type_known = i_cfg.type_mask[i_state.frame_type[7:6]][i_state.frame_type[5:0]];

    always_comb begin
        n_state  = i_state;
        n_status = ST_MORE;
        n_acc    = 1'b0;
        n_pv     = 1'b0;
        if (i_op == OP_SOFT_RST) begin
            n_state          = '0;
            n_state.poisoned = i_state.poisoned;
        end else if (i_state.poisoned) begin
            n_status = ST_LEN;
        end else if (in_header) begin
            n_acc           = 1'b1;
            n_state.hdr_cnt = i_state.hdr_cnt + HDR_CNT_W'(1);
            unique case (i_state.hdr_cnt[2:0])
                3'd0: n_state.frame_type        = i_data_byte;
                3'd1: begin
                    // flags byte, ignored
                end
                3'd2: n_state.request_id[7:0]   = i_data_byte;
                3'd3: n_state.request_id[15:8]  = i_data_byte;
                3'd4: n_state.length[7:0]       = i_data_byte;
                3'd5: n_state.length[15:8]      = i_data_byte;
                3'd6: n_state.length[23:16]     = i_data_byte;
                3'd7: n_state.length[31:24]     = i_data_byte;
                default: ;
            endcase
            if (i_state.hdr_cnt[2:0] == 3'd7) begin
                priority if (!type_known) begin
                    n_state.poisoned = 1'b1;
                    n_status         = ST_TYPE;
                end else if (len_full > i_cfg.max_payload) begin
                    n_state.poisoned = 1'b1;
                    n_status         = ST_LEN;
                end else if (len_full > i_cfg.capacity) begin
                    n_state.poisoned = 1'b1;
                    n_status         = ST_CAP;
                end else begin
                    n_state.pay_cnt = '0;
                    if (len_full == 32'd0) begin
                        n_state.hdr_cnt = '0;
                        n_status        = ST_FRAME;
                    end
                end
            end
        end else begin
            // payload byte: passed through with its offset
            n_acc           = 1'b1;
            n_pv            = 1'b1;
            n_state.pay_cnt = pay_next;
            if (pay_next >= i_state.length) begin
                n_state.hdr_cnt = '0;
                n_status        = ST_FRAME;
            end
        end
    end

    assign o_state                 = n_state;
    assign o_result.status         = n_status;
    assign o_result.accepted       = n_acc;
    assign o_result.payload_valid  = n_pv;
    assign o_result.payload_byte   = n_pv ? i_data_byte : 8'd0;
    assign o_result.payload_offset = n_pv ? i_state.pay_cnt : 32'd0;
    assign o_result.frame_type     = n_state.frame_type;
    assign o_result.request_id     = n_state.request_id;
    assign o_result.payload_length = n_state.length;

endmodule

// ----- rtl/core/length_prefixed_frame_parser.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser
// Byte-stream deframer for frames with an 8-byte little-endian header.
// ----------------------------------------------------------------------------
// The parser takes one transfer per clock on its input: either a stream byte
// (op 0) or a soft reset of frame progress (op 1), and gives exactly one
// result transfer for each, as long as the output side is not stalled. A byte
// is registered on entry, processed against the frame state, and its result
// lands in the output register; the state update (header byte capture, 32-bit
// length compares, payload counter) is combinational between the two
// registers. The header is type, flags (ignored), 16-bit request id, 32-bit
// length. On the eighth byte the type is checked against the 256-bit type
// mask, then the length against max_payload, then against capacity; any
// failure latches a sticky poisoned flag after which every byte is refused
// with the bad-length status. Only i_rst_n clears that flag. Payload bytes are
// not stored: each is presented with its offset. Configuration is written
// through a plain write port; the user must write it only while the parser
// is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [lpfp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lpfp_pkg::CFG_DATA_W-1:0] i_cfg_data,

    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_op,
    input  logic [7:0]                      i_data_byte,

    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [2:0]                      o_status,
    output logic                            o_accepted,
    output logic                            o_payload_valid,
    output logic [7:0]                      o_payload_byte,
    output logic [31:0]                     o_payload_offset,
    output logic [7:0]                      o_frame_type,
    output logic [15:0]                     o_request_id,
    output logic [31:0]                     o_payload_length
);
    import lpfp_pkg::*;

    t_cfg    cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;

    logic       r_in_valid;
    logic       r_in_op;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic       advance;

    lpfp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lpfp_step u_step (
        .i_op        (r_in_op),
        .i_data_byte (r_in_byte),
        .i_cfg       (cfg),
        .i_state     (r_state),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    // The pipe moves when the output register is empty or being drained.
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_op   <= i_op;
            r_in_byte <= i_data_byte;
        end
    end

    // Frame state: updated once per processed transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance && r_in_valid) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_result.status;
    assign o_accepted       = r_result.accepted;
    assign o_payload_valid  = r_result.payload_valid;
    assign o_payload_byte   = r_result.payload_byte;
    assign o_payload_offset = r_result.payload_offset;
    assign o_frame_type     = r_result.frame_type;
    assign o_request_id     = r_result.request_id;
    assign o_payload_length = r_result.payload_length;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Poisoned flag is sticky until hard reset.
    a_poison_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.poisoned |=> r_state.poisoned)
        else $error("poisoned flag cleared without reset");

    // Header counter never passes the header size.
    a_hdr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.hdr_cnt <= HDR_CNT_W'(HDR_BYTES))
        else $error("header count out of range");

    // In the payload phase the offset stays below the frame length.
    a_pay_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_state.poisoned && r_state.hdr_cnt == HDR_CNT_W'(HDR_BYTES))
            |-> (r_state.pay_cnt < r_state.length))
        else $error("payload counter reached frame length");

    // A payload byte is always consumed and never carries an error status.
    a_pay_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_payload_valid)
            |-> (o_accepted && (o_status == ST_MORE || o_status == ST_FRAME)))
        else $error("payload byte with error status");

endmodule
